>>> src/crater_stamp_height_map_assert.svh
// ----------------------------------------------------------------------------
// crater stamp height map assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CRATER_STAMP_HEIGHT_MAP_ASSERT_SVH
`define CRATER_STAMP_HEIGHT_MAP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CSH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csh check failed");

// consequent must hold in the cycle after the antecedent
`define CSH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csh check failed");

`endif

>>> src/csh_pkg.sv
// ----------------------------------------------------------------------------
// csh_pkg
// shared widths, codes and control types of the crater stamp height map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csh_pkg;

    localparam int GRID_BITS  = 8;
    localparam int GRID_SIDE  = 1 << GRID_BITS;
    localparam int ADDR_W     = 2 * GRID_BITS;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int BOUND_W    = GRID_BITS + 1;

    localparam int FRAC_BITS  = 8;
    localparam int COORD_W    = 16;
    localparam int DIAM_W     = 17;
    localparam int HEIGHT_W   = 18;
    localparam int COUNT_W    = 17;
    localparam int K_W        = 16;

    localparam logic [K_W-1:0]     K_RESET   = 16'd13107;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // offsets in half-lsb units
    localparam int OFS_FULL_W = COORD_W + 3;
    localparam int OFS_W      = OFS_FULL_W - 1;
    localparam int SQ_W       = 2 * OFS_W - 2;
    localparam int D2_W       = SQ_W + 1;
    localparam int RSQ_W      = 2 * DIAM_W;
    localparam int PROD_W     = K_W + RSQ_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int QUO_W      = DIAM_W;
    localparam int DIV_STAGES = QUO_W;

    localparam logic [DIAM_W:0] CEIL_ADD = (DIAM_W+1)'((1 << FRAC_BITS) - 1);

    localparam logic OP_STAMP = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_DONE
    } csh_state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic walk;
        logic read_issue;
        logic read_capture;
    } csh_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic box_empty;
        logic walk_last;
        logic busy;
    } csh_status_t;

endpackage

`default_nettype wire

>>> src/csh_in_if.sv
// ----------------------------------------------------------------------------
// csh_in_if
// input channel: one beat is a stamp or a cell read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface csh_in_if import csh_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [COORD_W-1:0]   center_x;
    logic [COORD_W-1:0]   center_y;
    logic [DIAM_W-1:0]    crater_diameter;
    logic [GRID_BITS-1:0] cell_row;
    logic [GRID_BITS-1:0] cell_col;

    modport source (
        output valid, operation, center_x, center_y, crater_diameter, cell_row, cell_col,
        input  ready
    );

    modport sink (
        input  valid, operation, center_x, center_y, crater_diameter, cell_row, cell_col,
        output ready
    );
endinterface

`default_nettype wire

>>> src/csh_out_if.sv
// ----------------------------------------------------------------------------
// csh_out_if
// result channel: one beat per accepted input beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface csh_out_if import csh_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] read_height;
    logic [COUNT_W-1:0]         cells_lowered;

    modport source (
        output valid, read_height, cells_lowered,
        input  ready
    );

    modport sink (
        input  valid, read_height, cells_lowered,
        output ready
    );
endinterface

`default_nettype wire

>>> src/csh_controller.sv
// ----------------------------------------------------------------------------
// csh_controller
// sequencer for clearing, stamp walk, pipeline drain and cell reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csh_controller import csh_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_operation,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output csh_cmd_t    cmd,
    input  csh_status_t status
);

    csh_state_t state_reg;
    csh_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_operation == OP_READ) ? ST_READ_ADDR : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.box_empty)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.walk = 1'b1;
                    if (status.walk_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_ADDR:
            begin
                cmd.read_issue = 1'b1;
                state_next     = ST_READ_DATA;
            end
            ST_READ_DATA:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/csh_datapath.sv
// ----------------------------------------------------------------------------
// csh_datapath
// height memory, bounding box walk, depth pipeline with staged divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csh_datapath import csh_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [K_W-1:0]             cfg_wdata,
    input  logic [COORD_W-1:0]         center_x,
    input  logic [COORD_W-1:0]         center_y,
    input  logic [DIAM_W-1:0]          crater_diameter,
    input  logic [GRID_BITS-1:0]       cell_row,
    input  logic [GRID_BITS-1:0]       cell_col,
    input  csh_cmd_t                   cmd,
    output csh_status_t                status,
    output logic signed [HEIGHT_W-1:0] read_height,
    output logic [COUNT_W-1:0]         cells_lowered
);

    function automatic logic [BOUND_W-1:0] clip_grid(input logic signed [DIAM_W:0] v);
        logic [BOUND_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > GRID_SIDE)
        begin
            res = BOUND_W'(GRID_SIDE);
        end
        else
        begin
            res = v[BOUND_W-1:0];
        end
        return res;
    endfunction

    // configuration
    logic [K_W-1:0] k_reg;

    // item latch
    logic [COORD_W-1:0]   cx_reg;
    logic [COORD_W-1:0]   cy_reg;
    logic [DIAM_W-1:0]    diam_reg;
    logic [RSQ_W-1:0]     r_sq_reg;
    logic [BOUND_W-1:0]   x_lo_reg;
    logic [BOUND_W-1:0]   x_hi_reg;
    logic [BOUND_W-1:0]   y_hi_reg;
    logic [GRID_BITS-1:0] row_reg;
    logic [GRID_BITS-1:0] col_reg;
    logic [ADDR_W-1:0]    cell_addr_reg;
    logic                 box_empty_reg;

    // bounding box
    logic signed [DIAM_W:0] x_lo_raw;
    logic signed [DIAM_W:0] y_lo_raw;
    logic [DIAM_W:0]        x_hi_raw;
    logic [DIAM_W:0]        y_hi_raw;
    logic [BOUND_W-1:0]     x_lo;
    logic [BOUND_W-1:0]     x_hi;
    logic [BOUND_W-1:0]     y_lo;
    logic [BOUND_W-1:0]     y_hi;

    // walk
    logic col_last;
    logic row_last;

    // pipeline
    logic                     s1_v_reg;
    logic signed [OFS_W-1:0]  s1_dx_reg;
    logic signed [OFS_W-1:0]  s1_dy_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic signed [OFS_FULL_W-1:0] dx_full;
    logic signed [OFS_FULL_W-1:0] dy_full;

    logic                     s2_v_reg;
    logic [SQ_W-1:0]          s2_sqx_reg;
    logic [SQ_W-1:0]          s2_sqy_reg;
    logic [ADDR_W-1:0]        s2_addr_reg;
    logic signed [2*OFS_W-1:0] prod_x;
    logic signed [2*OFS_W-1:0] prod_y;

    logic                     s3_v_reg;
    logic [RSQ_W-1:0]         s3_diff_reg;
    logic [ADDR_W-1:0]        s3_addr_reg;
    logic [D2_W-1:0]          d2;
    logic                     in_crater;

    logic                     s4_v_reg;
    logic [PROD_W-1:0]        s4_prod_reg;
    logic [ADDR_W-1:0]        s4_addr_reg;

    logic [DIV_STAGES:0]      div_v_reg;
    logic [NUM_W-1:0]         div_rem_reg  [DIV_STAGES+1];
    logic [QUO_W-1:0]         div_q_reg    [DIV_STAGES+1];
    logic [ADDR_W-1:0]        div_addr_reg [DIV_STAGES+1];
    logic [NUM_W-1:0]         div_sub      [DIV_STAGES];
    logic [DIV_STAGES-1:0]    div_ge;
    logic [NUM_W-1:0]         round_add;

    logic                       rmw_v_reg;
    logic signed [HEIGHT_W-1:0] rmw_depth_reg;
    logic [ADDR_W-1:0]          rmw_addr_reg;
    logic signed [HEIGHT_W-1:0] depth;
    logic                       lower;

    // memory
    logic signed [HEIGHT_W-1:0] height_map [CELL_COUNT];
    logic signed [HEIGHT_W-1:0] mem_q_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          clr_addr_reg;

    // results
    logic signed [HEIGHT_W-1:0] res_height_reg;
    logic [COUNT_W-1:0]         count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_we)
        begin
            k_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        x_lo_raw = $signed({2'b00, center_x}) - $signed({1'b0, crater_diameter});
        y_lo_raw = $signed({2'b00, center_y}) - $signed({1'b0, crater_diameter});
        x_hi_raw = ({2'b00, center_x} + {1'b0, crater_diameter} + CEIL_ADD) >> FRAC_BITS;
        y_hi_raw = ({2'b00, center_y} + {1'b0, crater_diameter} + CEIL_ADD) >> FRAC_BITS;
        x_lo     = clip_grid(x_lo_raw >>> FRAC_BITS);
        y_lo     = clip_grid(y_lo_raw >>> FRAC_BITS);
        x_hi     = clip_grid($signed(x_hi_raw));
        y_hi     = clip_grid($signed(y_hi_raw));
    end

    assign col_last = ({1'b0, col_reg} + BOUND_W'(1)) == x_hi_reg;
    assign row_last = ({1'b0, row_reg} + BOUND_W'(1)) == y_hi_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg        <= center_x;
            cy_reg        <= center_y;
            diam_reg      <= crater_diameter;
            r_sq_reg      <= RSQ_W'(crater_diameter) * RSQ_W'(crater_diameter);
            x_lo_reg      <= x_lo;
            x_hi_reg      <= x_hi;
            y_hi_reg      <= y_hi;
            row_reg       <= y_lo[GRID_BITS-1:0];
            col_reg       <= x_lo[GRID_BITS-1:0];
            cell_addr_reg <= {cell_row, cell_col};
            box_empty_reg <= (crater_diameter == '0) || (x_lo >= x_hi) || (y_lo >= y_hi);
        end
        else if (cmd.walk)
        begin
            if (col_last)
            begin
                col_reg <= x_lo_reg[GRID_BITS-1:0];
                row_reg <= row_reg + GRID_BITS'(1);
            end
            else
            begin
                col_reg <= col_reg + GRID_BITS'(1);
            end
        end
    end

    // stage 1: offsets from the center
    assign dx_full = $signed({2'b00, col_reg, {(FRAC_BITS+1){1'b0}}})
                   - $signed({2'b00, cx_reg, 1'b0});
    assign dy_full = $signed({2'b00, row_reg, {(FRAC_BITS+1){1'b0}}})
                   - $signed({2'b00, cy_reg, 1'b0});

    // stage 2: squares
    assign prod_x = s1_dx_reg * s1_dx_reg;
    assign prod_y = s1_dy_reg * s1_dy_reg;

    // stage 3: inside test and r^2 - d^2
    assign d2        = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
    assign in_crater = d2 <= {1'b0, r_sq_reg};

    // divider shifted divisors
    assign round_add = NUM_W'({diam_reg, {(K_W-1){1'b0}}});

    always_comb
    begin
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            div_sub[i] = NUM_W'(diam_reg) << (K_W + DIV_STAGES - 1 - i);
            div_ge[i]  = div_rem_reg[i] >= div_sub[i];
        end
    end

    assign depth = -$signed({1'b0, div_q_reg[DIV_STAGES]});

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= dx_full[OFS_W-1:0];
        s1_dy_reg   <= dy_full[OFS_W-1:0];
        s1_addr_reg <= {row_reg, col_reg};

        s2_sqx_reg  <= prod_x[SQ_W-1:0];
        s2_sqy_reg  <= prod_y[SQ_W-1:0];
        s2_addr_reg <= s1_addr_reg;

        s3_diff_reg <= r_sq_reg - d2[RSQ_W-1:0];
        s3_addr_reg <= s2_addr_reg;

        s4_prod_reg <= PROD_W'(k_reg) * PROD_W'(s3_diff_reg);
        s4_addr_reg <= s3_addr_reg;

        div_rem_reg[0]  <= {1'b0, s4_prod_reg} + round_add;
        div_q_reg[0]    <= '0;
        div_addr_reg[0] <= s4_addr_reg;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            div_rem_reg[i+1]  <= div_ge[i] ? (div_rem_reg[i] - div_sub[i]) : div_rem_reg[i];
            div_q_reg[i+1]    <= {div_q_reg[i][QUO_W-2:0], div_ge[i]};
            div_addr_reg[i+1] <= div_addr_reg[i];
        end

        rmw_depth_reg <= depth;
        rmw_addr_reg  <= div_addr_reg[DIV_STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            div_v_reg <= '0;
            rmw_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= cmd.walk;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg && in_crater;
            s4_v_reg  <= s3_v_reg;
            div_v_reg <= {div_v_reg[DIV_STAGES-1:0], s4_v_reg};
            rmw_v_reg <= div_v_reg[DIV_STAGES];
        end
    end

    // read-modify-write of the height memory
    assign rd_addr = cmd.read_issue ? cell_addr_reg : div_addr_reg[DIV_STAGES];
    assign lower   = rmw_v_reg && (rmw_depth_reg < mem_q_reg);

    always_ff @(posedge clk)
    begin
        mem_q_reg <= height_map[rd_addr];
        if (cmd.clear)
        begin
            height_map[clr_addr_reg] <= '0;
        end
        else if (lower)
        begin
            height_map[rmw_addr_reg] <= rmw_depth_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= '0;
        end
        else if (lower && (count_reg != COUNT_MAX))
        begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_height_reg <= '0;
        end
        else if (cmd.load)
        begin
            res_height_reg <= '0;
        end
        else if (cmd.read_capture)
        begin
            res_height_reg <= mem_q_reg;
        end
    end

    assign status.clear_last = (clr_addr_reg == '1);
    assign status.box_empty  = box_empty_reg;
    assign status.walk_last  = col_last && row_last;
    assign status.busy       = s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg
                             || (|div_v_reg) || rmw_v_reg;

    assign read_height   = res_height_reg;
    assign cells_lowered = count_reg;

endmodule

`default_nettype wire

>>> src/crater_stamp_height_map.sv
// ----------------------------------------------------------------------------
// crater_stamp_height_map
// 256 x 256 height map lowered by crater stamps, with single-cell reads
//
// item beats carry a stamp (center, diameter) or a cell read (row, col);
// every item gives exactly one result beat, and items are handled one at a time
// the depth_to_diameter register is written through cfg_we / cfg_wdata
// after reset a clearing pass writes zero to all 65536 cells, one per cycle;
// item.ready stays low until that pass is over
// a stamp walks its clipped bounding box one cell per cycle into a 23-stage
// depth pipeline (squares, product, 17-step divider, memory read-modify-write);
// its result beat is offered once the walk is over and the pipeline has drained,
// or after the walk and drain states alone when the box is empty
// a read issues the cell address, captures the memory word, then offers its beat
// the next item is taken in the cycle after the result beat at the earliest
// the result stays on result until result.ready; item.ready is low meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crater_stamp_height_map import csh_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [K_W-1:0] cfg_wdata,
    csh_in_if.sink         item,
    csh_out_if.source      result
);

    csh_cmd_t    cmd;
    csh_status_t status;

    csh_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (item.valid),
        .in_operation (item.operation),
        .in_ready     (item.ready),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .cmd          (cmd),
        .status       (status)
    );

    csh_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .center_x        (item.center_x),
        .center_y        (item.center_y),
        .crater_diameter (item.crater_diameter),
        .cell_row        (item.cell_row),
        .cell_col        (item.cell_col),
        .cmd             (cmd),
        .status          (status),
        .read_height     (result.read_height),
        .cells_lowered   (result.cells_lowered)
    );

endmodule

`default_nettype wire

>>> src/csh_checker.sv
// ----------------------------------------------------------------------------
// csh_checker
// port-level checks of the crater stamp height map, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "crater_stamp_height_map_assert.svh"

module csh_checker import csh_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [HEIGHT_W-1:0] read_height,
    input logic [COUNT_W-1:0]         cells_lowered
);

    // result beat holds until taken
    `CSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // one item in flight at a time
    `CSH_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

    `CSH_ASSERT_SAME(a_no_overlap, out_valid, !in_ready)

    // stamp results read zero height, read results lower nothing
    `CSH_ASSERT_SAME(a_one_kind, out_valid, (read_height == '0) || (cells_lowered == '0))

    // heights never rise above zero
    `CSH_ASSERT_SAME(a_height_sign, out_valid, read_height[HEIGHT_W-1] || (read_height == '0))

endmodule

bind crater_stamp_height_map csh_checker u_csh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .read_height   (result.read_height),
    .cells_lowered (result.cells_lowered)
);

`default_nettype wire

>>> verif/crater_stamp_height_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crater_stamp_height_map_tb
// self-checking bench for the crater stamp height map
//
// a behavioral copy of the height map predicts every result beat: stamps are
// walked cell by cell in integer arithmetic and reads return the predicted
// cell. directed tests cover the empty map, single and repeated craters,
// clipping at the grid edges, full-grid craters and the ratio extremes; a
// random part then drops clustered, edge and repeated craters under several
// depth ratios, with reads aimed mostly near recent craters. both handshake
// sides idle at random, and each result beat is compared field by field.
// ----------------------------------------------------------------------------

module crater_stamp_height_map_tb import csh_pkg::*; ();

    localparam int LIMIT_CYCLES  = 6_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1880;
    localparam int PHASES        = 4;

    typedef struct {
        logic                 op;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [DIAM_W-1:0]    diam;
        logic [GRID_BITS-1:0] row;
        logic [GRID_BITS-1:0] col;
    } crater_item_t;

    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        logic [COUNT_W-1:0]         lowered;
    } map_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [K_W-1:0] cfg_wdata;

    csh_in_if  item_ch ();
    csh_out_if result_ch ();

    crater_stamp_height_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    // predicted block state
    int             height_at [CELL_COUNT];
    logic [K_W-1:0] crater_k = K_RESET;

    map_result_t  awaited_results [$];
    int           failures      = 0;
    int           cycle_count   = 0;
    bit           no_idle       = 0;
    int           stamps_sent   = 0;
    int           reads_sent    = 0;
    longint       cells_lowered = 0;
    int           deep_reads    = 0;
    int           ratio_writes  = 0;
    crater_item_t last_stamp;
    bit           have_stamp    = 0;
    int           hot_x         = 128;
    int           hot_y         = 128;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 awaited_results.size());
        $display("** crater_stamp_height_map: FAILED **");
        $finish;
    end

    function automatic longint grid_clip(longint v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > GRID_SIDE)
        begin
            return GRID_SIDE;
        end
        return v;
    endfunction

    function automatic int stamp_crater(int cx, int cy, int diam);
        longint x_lo, x_hi, y_lo, y_hi;
        longint dx, dy, d2, r_sq, den, mag;
        int     lowered;
        int     idx;
        lowered = 0;
        if (diam == 0)
        begin
            return 0;
        end
        // bounds floor(c - 2r) to ceil(c + 2r) in cells, with c and r in lsb units
        x_lo = grid_clip((longint'(cx) - diam) >>> FRAC_BITS);
        x_hi = grid_clip(-((-(longint'(cx) + diam)) >>> FRAC_BITS));
        y_lo = grid_clip((longint'(cy) - diam) >>> FRAC_BITS);
        y_hi = grid_clip(-((-(longint'(cy) + diam)) >>> FRAC_BITS));
        r_sq = longint'(diam) * diam;
        den  = longint'(diam) <<< 16;
        for (longint row = y_lo; row < y_hi; row++)
        begin
            dy = (row <<< (FRAC_BITS + 1)) - 2 * longint'(cy);
            for (longint col = x_lo; col < x_hi; col++)
            begin
                dx = (col <<< (FRAC_BITS + 1)) - 2 * longint'(cx);
                d2 = dx * dx + dy * dy;
                if (d2 <= r_sq)
                begin
                    mag = (longint'(crater_k) * (r_sq - d2) + (den >>> 1)) / den;
                    if (mag > 131072)
                    begin
                        mag = 131072;
                    end
                    idx = int'(row) * GRID_SIDE + int'(col);
                    if (-mag < height_at[idx])
                    begin
                        height_at[idx] = -int'(mag);
                        if (lowered < COUNT_MAX)
                        begin
                            lowered++;
                        end
                    end
                end
            end
        end
        return lowered;
    endfunction

    function automatic map_result_t apply_item(crater_item_t it);
        map_result_t res;
        int          h;
        res.height  = '0;
        res.lowered = '0;
        if (it.op == OP_STAMP)
        begin
            res.lowered = COUNT_W'(stamp_crater(int'(it.cx), int'(it.cy), int'(it.diam)));
            stamps_sent++;
            cells_lowered += res.lowered;
        end
        else
        begin
            h = height_at[int'(it.row) * GRID_SIDE + int'(it.col)];
            res.height = HEIGHT_W'(h);
            reads_sent++;
            if (h != 0)
            begin
                deep_reads++;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_idle)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 80);
    endfunction

    function automatic crater_item_t make_stamp(int cx, int cy, int diam);
        crater_item_t it;
        it.op   = OP_STAMP;
        it.cx   = COORD_W'(cx);
        it.cy   = COORD_W'(cy);
        it.diam = DIAM_W'(diam);
        it.row  = GRID_BITS'($urandom);
        it.col  = GRID_BITS'($urandom);
        return it;
    endfunction

    function automatic crater_item_t make_read(int row, int col);
        crater_item_t it;
        it.op   = OP_READ;
        it.cx   = COORD_W'($urandom);
        it.cy   = COORD_W'($urandom);
        it.diam = DIAM_W'($urandom);
        it.row  = GRID_BITS'(row);
        it.col  = GRID_BITS'(col);
        return it;
    endfunction

    function automatic int near_coord(int base, int spread, int top);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
        begin
            return 0;
        end
        if (v > top)
        begin
            return top;
        end
        return v;
    endfunction

    function automatic crater_item_t random_item();
        crater_item_t it;
        int           roll;
        it = make_read($urandom, $urandom);
        if ($urandom_range(0, 99) < 55)
        begin
            if (have_stamp && $urandom_range(0, 99) < 6)
            begin
                return last_stamp;
            end
            it.op = OP_STAMP;
            roll  = $urandom_range(0, 99);
            if (roll < 45)
            begin
                it.cx = COORD_W'(near_coord(hot_x * 256, 2048, 65535));
                it.cy = COORD_W'(near_coord(hot_y * 256, 2048, 65535));
            end
            else if (roll < 57)
            begin
                it.cx = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 767))
                                             : COORD_W'(65535 - $urandom_range(0, 767));
                it.cy = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 767))
                                             : COORD_W'(65535 - $urandom_range(0, 767));
            end
            roll = $urandom_range(0, 999);
            if (roll < 30)
            begin
                it.diam = '0;
            end
            else if (roll < 830)
            begin
                it.diam = DIAM_W'($urandom_range(1, 2047));
            end
            else if (roll < 980)
            begin
                it.diam = DIAM_W'($urandom_range(2048, 4095));
            end
            else if (roll < 998)
            begin
                it.diam = DIAM_W'($urandom_range(4096, 8191));
            end
            last_stamp = it;
            have_stamp = 1;
        end
        else if (have_stamp && $urandom_range(0, 99) < 70)
        begin
            it.row = GRID_BITS'(near_coord(int'(last_stamp.cy) >> FRAC_BITS, 4, 255));
            it.col = GRID_BITS'(near_coord(int'(last_stamp.cx) >> FRAC_BITS, 4, 255));
        end
        return it;
    endfunction

    task automatic send_item(crater_item_t it);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge clk);
        @(negedge clk);
        item_ch.operation       = it.op;
        item_ch.center_x        = it.cx;
        item_ch.center_y        = it.cy;
        item_ch.crater_diameter = it.diam;
        item_ch.cell_row        = it.row;
        item_ch.cell_col        = it.col;
        item_ch.valid           = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (item_ch.ready !== 1'b1);
        awaited_results.push_back(apply_item(it));
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_depth_ratio(logic [K_W-1:0] k);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = k;
        @(negedge clk);
        cfg_we    = 1'b0;
        crater_k  = k;
        ratio_writes++;
    endtask

    task automatic log_mismatch(string what, string want, string got);
        failures++;
        $display("%0t ns: %s mismatch, expected %s, actual %s", $time, what, want, got);
    endtask

    // result side: random stalls on ready
    initial
    begin
        int stretch;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stretch = $urandom_range(1, 40);
            repeat (stretch)
            begin
                @(negedge clk);
                result_ch.ready = 1'b1;
            end
            stretch = pick_gap();
            repeat (stretch)
            begin
                @(negedge clk);
                result_ch.ready = 1'b0;
            end
        end
    end

    // result beat checker
    initial
    begin
        map_result_t want;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    log_mismatch("unexpected beat", "none",
                                 $sformatf("height %0d lowered %0d",
                                           result_ch.read_height, result_ch.cells_lowered));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_ch.read_height !== want.height)
                    begin
                        log_mismatch("read_height", $sformatf("%0d", want.height),
                                     $sformatf("%0d", result_ch.read_height));
                    end
                    if (result_ch.cells_lowered !== want.lowered)
                    begin
                        log_mismatch("cells_lowered", $sformatf("%0d", want.lowered),
                                     $sformatf("%0d", result_ch.cells_lowered));
                    end
                end
            end
        end
    end

    task automatic test_empty_map_reads();
        send_item(make_read(0, 0));
        send_item(make_read(0, 255));
        send_item(make_read(255, 0));
        send_item(make_read(255, 255));
        send_item(make_stamp(32896, 32896, 0));
        send_item(make_read(128, 128));
    endtask

    task automatic test_single_crater();
        send_item(make_stamp(5248, 7744, 768));
        send_item(make_read(30, 20));
        send_item(make_read(30, 21));
        // same crater again lowers nothing
        send_item(make_stamp(5248, 7744, 768));
        send_item(make_stamp(5248, 7744, 1024));
        send_item(make_read(31, 20));
    endtask

    task automatic test_grid_edges();
        send_item(make_stamp(65535, 65535, 1024));
        send_item(make_stamp(0, 0, 1024));
        send_item(make_stamp(0, 65535, 600));
        send_item(make_read(255, 255));
        send_item(make_read(0, 0));
    endtask

    task automatic test_full_grid_craters();
        // shallow crater over every cell
        set_depth_ratio(16'd16);
        send_item(make_stamp(32768, 32768, 131071));
        send_item(make_read(128, 128));
        send_item(make_read(0, 255));
        set_depth_ratio(16'd0);
        send_item(make_stamp(16384, 49152, 65536));
        set_depth_ratio(16'hFFFF);
        send_item(make_stamp(40000, 12000, 1500));
        send_item(make_read(47, 156));
    endtask

    task automatic test_random_craters();
        logic [K_W-1:0] ratios [PHASES];
        int             per_phase;
        ratios[0] = K_RESET;
        ratios[1] = 16'hFFFF;
        ratios[2] = K_W'($urandom_range(2000, 30000));
        ratios[3] = K_W'($urandom);
        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            set_depth_ratio(ratios[p]);
            hot_x = $urandom_range(16, 240);
            hot_y = $urandom_range(16, 240);
            for (int n = 0; n < per_phase; n++)
            begin
                if (p == 1 && n == per_phase / 2)
                begin
                    wait_idle();
                end
                no_idle = (p == 2 && n < 150);
                send_item(random_item());
            end
        end
        no_idle = 0;
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        item_ch.valid           = 1'b0;
        item_ch.operation       = OP_STAMP;
        item_ch.center_x        = '0;
        item_ch.center_y        = '0;
        item_ch.crater_diameter = '0;
        item_ch.cell_row        = '0;
        item_ch.cell_col        = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_empty_map_reads();
        test_single_crater();
        test_grid_edges();
        test_full_grid_craters();
        test_random_craters();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d stamps lowering %0d cells and %0d reads, %0d of them below zero,",
                 stamps_sent, cells_lowered, reads_sent, deep_reads);
        $display("under %0d depth ratio writes in %0d cycles", ratio_writes, cycle_count);
        if (failures == 0 && awaited_results.size() == 0)
        begin
            $display("** crater_stamp_height_map: PASSED **");
        end
        else
        begin
            $display("** crater_stamp_height_map: FAILED **");
        end
        $finish;
    end

endmodule
